// ===== rtl/core/cpss_pkg.sv =====
// Shared types and constants for the segment-to-segment closest point pipeline.
`timescale 1ns / 1ps
package cpss_pkg;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int DW     = CW + 1;
    localparam int DOTW   = 2 * DW + 1;
    localparam int PW     = FB + 1;
    localparam int GW     = 63;
    localparam int THR_W  = 32;
    localparam int MUL_CH = 17;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(512);
    localparam logic [PW-1:0]    PARAM_ONE = {1'b1, {FB{1'b0}}};
    localparam logic [GW-1:0]    GAP_MAX   = {GW{1'b1}};

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_DIV  = 2'd1;
    localparam logic [1:0] SEL_PASS = 2'd2;
    localparam logic [1:0] SEL_ONE  = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
    } t_seg_pair;

    typedef struct packed {
        logic [PW-1:0]        param_s;
        logic [PW-1:0]        param_t;
        logic signed [CW-1:0] near_a_x;
        logic signed [CW-1:0] near_a_y;
        logic signed [CW-1:0] near_b_x;
        logic signed [CW-1:0] near_b_y;
        logic [GW-1:0]        gap_squared;
    } t_closest;

endpackage

// ===== rtl/core/cpss_mul.sv =====
// Pipelined wide signed multiplier, one slice of the second operand per stage.
`timescale 1ns / 1ps
module cpss_mul #(
    parameter int WA = 67,
    parameter int WB = 67,
    parameter int CH = 17
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int NCH = (WB + CH - 1) / CH;
    localparam int WE  = NCH * CH;
    localparam int WP  = WA + WB;

    logic signed [WA-1:0] r_a   [NCH];
    logic signed [WE-1:0] r_b   [NCH];
    logic signed [WP-1:0] r_acc [NCH];

    for (genvar i = 0; i < NCH; i++) begin : g_st
        logic signed [WA-1:0]   s_a;
        logic signed [WE-1:0]   s_b;
        logic signed [WP-1:0]   s_acc;
        logic signed [WA+CH:0]  s_pp;
        if (i == 0) begin : g_first
            assign s_a   = i_a;
            assign s_b   = WE'(i_b);
            assign s_acc = '0;
        end else begin : g_next
            assign s_a   = r_a[i-1];
            assign s_b   = r_b[i-1];
            assign s_acc = r_acc[i-1];
        end
        if (i == NCH - 1) begin : g_top
            assign s_pp = s_a * $signed(s_b[CH*i +: CH]);
        end else begin : g_low
            assign s_pp = s_a * $signed({1'b0, s_b[CH*i +: CH]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[i]   <= s_a;
                r_b[i]   <= s_b;
                r_acc[i] <= s_acc + (WP'(s_pp) <<< (CH * i));
            end
        end
    end

    assign o_p = r_acc[NCH-1];

endmodule

// ===== rtl/core/cpss_div.sv =====
// Pipelined clamped fraction divider, one quotient bit per stage.
`timescale 1ns / 1ps
module cpss_div import cpss_pkg::*; #(
    parameter int W = 69
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic [PW-1:0]       o_q
);
    logic [W:0]    r_rem [FB+1];
    logic [W-1:0]  r_den [FB+1];
    logic [FB-1:0] r_q   [FB+1];
    logic          r_fix [FB+1];
    logic          r_one [FB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num};
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_fix[0] <= (i_num <= 0) || (i_num >= i_den);
            r_one[0] <= (i_num > 0) && (i_num >= i_den);
        end
    end

    for (genvar j = 1; j <= FB; j++) begin : g_step
        logic [W:0]   s_sh;
        logic [W+1:0] s_diff;
        logic         s_take;
        assign s_sh   = {r_rem[j-1][W-1:0], 1'b0};
        assign s_diff = {1'b0, s_sh} - {2'b00, r_den[j-1]};
        assign s_take = !s_diff[W+1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= s_take ? s_diff[W:0] : s_sh;
                r_den[j] <= r_den[j-1];
                r_q[j]   <= {r_q[j-1][FB-2:0], s_take};
                r_fix[j] <= r_fix[j-1];
                r_one[j] <= r_one[j-1];
            end
        end
    end

    assign o_q = r_fix[FB] ? (r_one[FB] ? PARAM_ONE : '0) : {1'b0, r_q[FB]};

endmodule

// ===== rtl/core/closest_points_segment_segment.sv =====
// Top level of the closest points between two 2D segments pipeline.
//
// Input channel: i_valid, o_stall, i_data carry one segment pair per transaction,
// taken at a clock edge where i_valid is high and o_stall is low. Output channel:
// o_valid, i_stall, o_data carry parameters s and t, the two nearest points and
// the saturated squared gap. Every input transaction gives one output transaction.
// The threshold at or below which a segment is treated as a point must be written
// by the user through i_cfg_we and i_cfg_data only while the pipeline is empty;
// the block does not enforce it. Unless stalled, one transaction is accepted each
// cycle; two fraction dividers in series with the wide multipliers set the depth.
// All stages advance together: while the output holds a transaction and i_stall
// is high, the whole pipeline freezes and o_stall is raised, so nothing is lost.
// A synchronous reset empties the pipeline and sets the threshold to 512.
`timescale 1ns / 1ps
module closest_points_segment_segment import cpss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_seg_pair        i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_closest         o_data,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_data
);
    localparam int L_MUL  = (DOTW + MUL_CH - 1) / MUL_CH;
    localparam int L_DIV  = FB + 1;
    localparam int K_DIFF = 2;
    localparam int K_DOT  = K_DIFF + 2;
    localparam int K_S0   = K_DOT + L_MUL + 1 + L_DIV;
    localparam int K_CLS  = K_S0 + 2;
    localparam int K_Q    = K_CLS + L_DIV;
    localparam int K_ST   = K_Q + 1;
    localparam int K_PT   = K_ST + 2;
    localparam int K_OUT  = K_PT + 3;
    localparam int N_DOT  = K_S0 - K_DOT;
    localparam int N_CTL  = K_Q - K_CLS;
    localparam int N_GEO  = K_ST - K_DIFF;
    localparam int N_ST   = K_OUT - K_ST - 1;
    localparam int N_PT   = K_OUT - K_PT - 1;
    localparam int BPW    = 2 * DOTW;
    localparam int DNW    = BPW + 2;
    localparam int TNW    = DOTW + FB + 3;
    localparam int SNW    = DOTW + 2;
    localparam int MPW    = DW + PW + 1;
    localparam int GSW    = 2 * DW + 1;

    typedef struct packed {
        logic signed [DW-1:0] d1x;
        logic signed [DW-1:0] d1y;
        logic signed [DW-1:0] d2x;
        logic signed [DW-1:0] d2y;
        logic signed [CW-1:0] ax0;
        logic signed [CW-1:0] ay0;
        logic signed [CW-1:0] bx0;
        logic signed [CW-1:0] by0;
    } t_geo;

    typedef struct packed {
        logic signed [DOTW-1:0] a;
        logic signed [DOTW-1:0] e;
        logic signed [DOTW-1:0] b;
        logic signed [DOTW-1:0] c;
        logic signed [DOTW-1:0] f;
    } t_dot;

    typedef struct packed {
        logic [1:0]    ssel;
        logic [1:0]    tsel;
        logic [PW-1:0] s0;
    } t_ctl;

    typedef struct packed {
        logic [PW-1:0] s;
        logic [PW-1:0] t;
    } t_st;

    logic                 en;
    logic [THR_W-1:0]     r_thr;
    logic [K_OUT:1]       r_vld;
    t_seg_pair            r_in;
    t_geo                 r_geo;
    logic signed [DW-1:0] r_rx;
    logic signed [DW-1:0] r_ry;
    logic signed [2*DW-1:0] r_pa [2];
    logic signed [2*DW-1:0] r_pe [2];
    logic signed [2*DW-1:0] r_pb [2];
    logic signed [2*DW-1:0] r_pc [2];
    logic signed [2*DW-1:0] r_pf [2];
    t_dot                 r_dot;
    t_dot                 r_dotd [N_DOT];
    logic signed [BPW-1:0] w_ae;
    logic signed [BPW-1:0] w_bb;
    logic signed [BPW-1:0] w_bf;
    logic signed [BPW-1:0] w_ce;
    logic signed [DNW-1:0] r_den;
    logic signed [DNW-1:0] r_num;
    logic [PW-1:0]        w_s0;
    logic signed [DOTW+PW:0] w_tn_pp;
    logic signed [TNW-1:0] r_tn;
    t_dot                 r_dk;
    logic                 r_apt;
    logic                 r_ept;
    logic [PW-1:0]        r_s0t;
    logic signed [TNW-1:0] w_es;
    logic [1:0]           n_ssel;
    logic [1:0]           n_tsel;
    logic signed [SNW-1:0] n_ns;
    logic signed [TNW-1:0] n_nt;
    logic signed [TNW-1:0] n_dt;
    t_ctl                 r_ctl;
    t_ctl                 r_ctld [N_CTL];
    logic signed [SNW-1:0] r_ns;
    logic signed [SNW-1:0] r_ds;
    logic signed [TNW-1:0] r_nt;
    logic signed [TNW-1:0] r_dt;
    logic [PW-1:0]        w_qs;
    logic [PW-1:0]        w_qt;
    t_geo                 r_geod [N_GEO];
    t_st                  r_st;
    t_st                  r_std [N_ST];
    logic signed [MPW-1:0] r_mp [4];
    logic signed [CW-1:0] r_p0 [4];
    logic signed [CW-1:0] r_pt [4];
    logic signed [CW-1:0] r_ptd [N_PT][4];
    logic signed [DW-1:0] r_gx;
    logic signed [DW-1:0] r_gy;
    logic signed [2*DW-1:0] r_sq [2];
    logic [GSW-1:0]       w_gap_sum;
    t_closest             r_out;
    t_geo                 w_g;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[K_OUT];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= THR_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[K_OUT-1:1], i_valid};
            end
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    cpss_mul #(.WA(DOTW), .WB(DOTW), .CH(MUL_CH)) u_mul_ae (
        .i_clk(i_clk), .i_en(en), .i_a(r_dot.a), .i_b(r_dot.e), .o_p(w_ae));
    cpss_mul #(.WA(DOTW), .WB(DOTW), .CH(MUL_CH)) u_mul_bb (
        .i_clk(i_clk), .i_en(en), .i_a(r_dot.b), .i_b(r_dot.b), .o_p(w_bb));
    cpss_mul #(.WA(DOTW), .WB(DOTW), .CH(MUL_CH)) u_mul_bf (
        .i_clk(i_clk), .i_en(en), .i_a(r_dot.b), .i_b(r_dot.f), .o_p(w_bf));
    cpss_mul #(.WA(DOTW), .WB(DOTW), .CH(MUL_CH)) u_mul_ce (
        .i_clk(i_clk), .i_en(en), .i_a(r_dot.c), .i_b(r_dot.e), .o_p(w_ce));

    cpss_div #(.W(DNW)) u_div_s0 (
        .i_clk(i_clk), .i_en(en),
        .i_num((r_den == 0) ? DNW'(0) : r_num),
        .i_den(r_den), .o_q(w_s0));

    cpss_div #(.W(SNW)) u_div_s (
        .i_clk(i_clk), .i_en(en), .i_num(r_ns), .i_den(r_ds), .o_q(w_qs));

    cpss_div #(.W(TNW)) u_div_t (
        .i_clk(i_clk), .i_en(en), .i_num(r_nt), .i_den(r_dt), .o_q(w_qt));

    assign w_tn_pp = r_dotd[N_DOT-1].b * $signed({1'b0, w_s0});
    assign w_es    = TNW'(r_dk.e) <<< FB;
    assign w_g     = r_geod[N_GEO-1];
    assign w_gap_sum = GSW'($unsigned(r_sq[0])) + GSW'($unsigned(r_sq[1]));

    always_comb begin
        n_ssel = SEL_ZERO;
        n_tsel = SEL_ZERO;
        n_ns   = -SNW'(r_dk.c);
        n_nt   = TNW'(r_dk.f);
        n_dt   = TNW'(r_dk.e);
        if (r_apt && r_ept) begin
            n_ssel = SEL_ZERO;
            n_tsel = SEL_ZERO;
        end else if (r_apt) begin
            n_tsel = SEL_DIV;
        end else if (r_ept) begin
            n_ssel = SEL_DIV;
        end else if (r_tn < 0) begin
            n_ssel = SEL_DIV;
        end else if (r_tn > w_es) begin
            n_ssel = SEL_DIV;
            n_tsel = SEL_ONE;
            n_ns   = SNW'(r_dk.b) - SNW'(r_dk.c);
        end else begin
            n_ssel = SEL_PASS;
            n_tsel = SEL_DIV;
            n_nt   = r_tn;
            n_dt   = w_es;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_data;

            r_geo.d1x <= DW'(r_in.a_end_x) - DW'(r_in.a_start_x);
            r_geo.d1y <= DW'(r_in.a_end_y) - DW'(r_in.a_start_y);
            r_geo.d2x <= DW'(r_in.b_end_x) - DW'(r_in.b_start_x);
            r_geo.d2y <= DW'(r_in.b_end_y) - DW'(r_in.b_start_y);
            r_geo.ax0 <= r_in.a_start_x;
            r_geo.ay0 <= r_in.a_start_y;
            r_geo.bx0 <= r_in.b_start_x;
            r_geo.by0 <= r_in.b_start_y;
            r_rx      <= DW'(r_in.a_start_x) - DW'(r_in.b_start_x);
            r_ry      <= DW'(r_in.a_start_y) - DW'(r_in.b_start_y);

            r_pa[0] <= r_geo.d1x * r_geo.d1x;
            r_pa[1] <= r_geo.d1y * r_geo.d1y;
            r_pe[0] <= r_geo.d2x * r_geo.d2x;
            r_pe[1] <= r_geo.d2y * r_geo.d2y;
            r_pb[0] <= r_geo.d1x * r_geo.d2x;
            r_pb[1] <= r_geo.d1y * r_geo.d2y;
            r_pc[0] <= r_geo.d1x * r_rx;
            r_pc[1] <= r_geo.d1y * r_ry;
            r_pf[0] <= r_geo.d2x * r_rx;
            r_pf[1] <= r_geo.d2y * r_ry;

            r_dot.a <= DOTW'(r_pa[0]) + DOTW'(r_pa[1]);
            r_dot.e <= DOTW'(r_pe[0]) + DOTW'(r_pe[1]);
            r_dot.b <= DOTW'(r_pb[0]) + DOTW'(r_pb[1]);
            r_dot.c <= DOTW'(r_pc[0]) + DOTW'(r_pc[1]);
            r_dot.f <= DOTW'(r_pf[0]) + DOTW'(r_pf[1]);

            r_dotd[0] <= r_dot;
            for (int k = 1; k < N_DOT; k++) begin
                r_dotd[k] <= r_dotd[k-1];
            end

            r_den <= DNW'(w_ae) - DNW'(w_bb);
            r_num <= DNW'(w_bf) - DNW'(w_ce);

            r_tn  <= TNW'(w_tn_pp) + (TNW'(r_dotd[N_DOT-1].f) <<< FB);
            r_dk  <= r_dotd[N_DOT-1];
            r_apt <= r_dotd[N_DOT-1].a <= $signed({{(DOTW-THR_W){1'b0}}, r_thr});
            r_ept <= r_dotd[N_DOT-1].e <= $signed({{(DOTW-THR_W){1'b0}}, r_thr});
            r_s0t <= w_s0;

            r_ctl.ssel <= n_ssel;
            r_ctl.tsel <= n_tsel;
            r_ctl.s0   <= r_s0t;
            r_ns       <= n_ns;
            r_ds       <= SNW'(r_dk.a);
            r_nt       <= n_nt;
            r_dt       <= n_dt;

            r_ctld[0] <= r_ctl;
            for (int k = 1; k < N_CTL; k++) begin
                r_ctld[k] <= r_ctld[k-1];
            end

            r_geod[0] <= r_geo;
            for (int k = 1; k < N_GEO; k++) begin
                r_geod[k] <= r_geod[k-1];
            end

            case (r_ctld[N_CTL-1].ssel)
                SEL_DIV:  r_st.s <= w_qs;
                SEL_PASS: r_st.s <= r_ctld[N_CTL-1].s0;
                default:  r_st.s <= '0;
            endcase
            case (r_ctld[N_CTL-1].tsel)
                SEL_DIV: r_st.t <= w_qt;
                SEL_ONE: r_st.t <= PARAM_ONE;
                default: r_st.t <= '0;
            endcase

            r_std[0] <= r_st;
            for (int k = 1; k < N_ST; k++) begin
                r_std[k] <= r_std[k-1];
            end

            r_mp[0] <= w_g.d1x * $signed({1'b0, r_st.s});
            r_mp[1] <= w_g.d1y * $signed({1'b0, r_st.s});
            r_mp[2] <= w_g.d2x * $signed({1'b0, r_st.t});
            r_mp[3] <= w_g.d2y * $signed({1'b0, r_st.t});
            r_p0[0] <= w_g.ax0;
            r_p0[1] <= w_g.ay0;
            r_p0[2] <= w_g.bx0;
            r_p0[3] <= w_g.by0;

            for (int k = 0; k < 4; k++) begin
                r_pt[k] <= CW'(MPW'(r_p0[k]) + (r_mp[k] >>> FB));
            end

            r_ptd[0] <= r_pt;
            for (int k = 1; k < N_PT; k++) begin
                r_ptd[k] <= r_ptd[k-1];
            end

            r_gx <= DW'(r_pt[0]) - DW'(r_pt[2]);
            r_gy <= DW'(r_pt[1]) - DW'(r_pt[3]);

            r_sq[0] <= r_gx * r_gx;
            r_sq[1] <= r_gy * r_gy;

            r_out.param_s     <= r_std[N_ST-1].s;
            r_out.param_t     <= r_std[N_ST-1].t;
            r_out.near_a_x    <= r_ptd[N_PT-1][0];
            r_out.near_a_y    <= r_ptd[N_PT-1][1];
            r_out.near_b_x    <= r_ptd[N_PT-1][2];
            r_out.near_b_y    <= r_ptd[N_PT-1][3];
            r_out.gap_squared <= (w_gap_sum > GSW'(GAP_MAX)) ? GAP_MAX : w_gap_sum[GW-1:0];
        end
    end

    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.param_s <= PARAM_ONE) && (o_data.param_t <= PARAM_ONE))
        else $error("parameter beyond one");

    a_clamp_recomputes_s: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[K_CLS] && r_ctl.tsel == SEL_ONE) |-> (r_ctl.ssel == SEL_DIV))
        else $error("t clamped to one without recomputing s");

    a_freeze_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");

endmodule
